// ----- design/swrdi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrdi_pkg: shared definitions for the stack with range delete and insert
// Sizes, operation and status codes, controller/datapath interface types and
// word conversion helpers.
// ----------------------------------------------------------------------------
package swrdi_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;

    localparam int AW     = $clog2(DEPTH);
    localparam int FW     = $clog2(DEPTH + 1);
    localparam int POS_W  = 7;
    localparam int FILL_W = 7;
    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 3;
    localparam int CW     = ((FW > POS_W) ? FW : POS_W) + 1;

    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DEL  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INS  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOKEY = 3'd4;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic              load;
        logic              set_st;
        logic [STAT_W-1:0] st_code;
        logic              push;
        logic              pop_rd;
        logic              pos_rd;
        logic              cap_data;
        logic              del_init;
        logic              del_step;
        logic              del_fin;
        logic              srch_init;
        logic              srch_step;
        logic              ins_init;
        logic              ins_step;
        logic              ins_fin;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              del_ok;
        logic              cnt_zero;
        logic              rd_ok;
        logic              match;
        logic              srch_done;
        logic              dn_done;
        logic              up_done;
    } dp_stat_t;

    function automatic word_t to_word(input logic [DATA_W-1:0] v);
        logic [63:0] x;
        x = 64'(signed'(v));
        return x[WORD_BITS-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] from_word(input word_t w);
        logic [63:0] x;
        x = 64'(signed'(w));
        return x[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/swrdi_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrdi_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swrdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- design/swrdi_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrdi_ctrl: operation sequencer
// Decodes the operation, checks its conditions and steps the datapath through
// the read, search and shift sequences.
// ----------------------------------------------------------------------------
module swrdi_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire swrdi_pkg::dp_stat_t st,
    output swrdi_pkg::dp_cmd_t      cmd,
    output logic                    busy,
    output logic                    done
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_RDWAIT = 7'b0000100,
        S_DEL    = 7'b0001000,
        S_SRCH   = 7'b0010000,
        S_MVUP   = 7'b0100000,
        S_RESP   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                case (st.func)
                    swrdi_pkg::FN_PUSH:
                    begin
                        if (st.full)
                        begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = swrdi_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    swrdi_pkg::FN_POP:
                    begin
                        if (st.empty)
                        begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = swrdi_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_RDWAIT;
                        end
                    end
                    swrdi_pkg::FN_DEL:
                    begin
                        if (!st.del_ok)
                        begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = swrdi_pkg::ST_RANGE;
                        end
                        else if (!st.cnt_zero)
                        begin
                            cmd.del_init = 1'b1;
                            state_next   = S_DEL;
                        end
                    end
                    swrdi_pkg::FN_INS:
                    begin
                        if (st.full)
                        begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = swrdi_pkg::ST_FULL;
                        end
                        else if (st.empty)
                        begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = swrdi_pkg::ST_NOKEY;
                        end
                        else
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRCH;
                        end
                    end
                    swrdi_pkg::FN_READ:
                    begin
                        if (!st.rd_ok)
                        begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = swrdi_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.pos_rd = 1'b1;
                            state_next = S_RDWAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_RDWAIT:
            begin
                cmd.cap_data = 1'b1;
                state_next   = S_RESP;
            end
            S_DEL:
            begin
                if (st.dn_done)
                begin
                    cmd.del_fin = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.del_step = 1'b1;
                end
            end
            S_SRCH:
            begin
                if (st.match)
                begin
                    cmd.ins_init = 1'b1;
                    state_next   = S_MVUP;
                end
                else if (st.srch_done)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = swrdi_pkg::ST_NOKEY;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                end
            end
            S_MVUP:
            begin
                if (st.up_done)
                begin
                    cmd.ins_fin = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.ins_step = 1'b1;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

endmodule
`default_nettype wire

// ----- design/swrdi_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrdi_dp: stack datapath
// Entry RAM, fill count, scan pointers and result registers. Shifts and the
// key search issue one RAM read per cycle; shifts write the prior read's data.
// ----------------------------------------------------------------------------
module swrdi_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire swrdi_pkg::dp_cmd_t             cmd,
    input  wire logic [swrdi_pkg::FUNC_W-1:0]   func,
    input  wire logic [swrdi_pkg::DATA_W-1:0]   value,
    input  wire logic [swrdi_pkg::POS_W-1:0]    position,
    input  wire logic [swrdi_pkg::POS_W-1:0]    count,
    input  wire logic [swrdi_pkg::DATA_W-1:0]   key,
    output swrdi_pkg::dp_stat_t                 st,
    output logic      [swrdi_pkg::DATA_W-1:0]   data,
    output logic      [swrdi_pkg::STAT_W-1:0]   status,
    output logic      [swrdi_pkg::FILL_W-1:0]   fill
);

    logic [swrdi_pkg::FUNC_W-1:0] func_reg;
    swrdi_pkg::word_t             value_reg;
    swrdi_pkg::word_t             key_reg;
    logic [swrdi_pkg::POS_W-1:0]  pos_reg;
    logic [swrdi_pkg::POS_W-1:0]  cnt_reg;
    logic [swrdi_pkg::FW-1:0]     fill_reg, fill_next;
    logic [swrdi_pkg::FW-1:0]     ptr_reg, ptr_next;
    logic [swrdi_pkg::AW-1:0]     a_reg, a_next;
    logic [swrdi_pkg::AW-1:0]     at_reg, at_next;
    logic [swrdi_pkg::AW-1:0]     dst_reg, dst_next;
    logic                         pend_reg, pend_next;
    logic [swrdi_pkg::DATA_W-1:0] data_reg, data_next;
    logic [swrdi_pkg::STAT_W-1:0] status_reg, status_next;

    logic [swrdi_pkg::CW-1:0]     pos_c, cnt_c, fill_c, del_end, pos_m1, src_init;
    logic [swrdi_pkg::FW-1:0]     fill_m1, ptr_m1, at_f;
    logic [swrdi_pkg::AW-1:0]     pos_addr, a_p1;
    logic                         del_issue, up_issue, srch_issue;

    logic                         ram_we;
    logic [swrdi_pkg::AW-1:0]     ram_waddr, ram_raddr;
    swrdi_pkg::word_t             ram_wdata, ram_rdata;

    swrdi_ram #(
        .WIDTH (swrdi_pkg::WORD_BITS),
        .DEPTH (swrdi_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_c    = swrdi_pkg::CW'(pos_reg);
    assign cnt_c    = swrdi_pkg::CW'(cnt_reg);
    assign fill_c   = swrdi_pkg::CW'(fill_reg);
    assign del_end  = pos_c + cnt_c;
    assign pos_m1   = pos_c - 1'b1;
    assign src_init = pos_m1 + cnt_c;
    assign pos_addr = pos_m1[swrdi_pkg::AW-1:0];
    assign fill_m1  = fill_reg - 1'b1;
    assign ptr_m1   = ptr_reg - 1'b1;
    assign at_f     = swrdi_pkg::FW'(at_reg);
    assign a_p1     = a_reg + 1'b1;

    assign del_issue  = (ptr_reg < fill_reg);
    assign up_issue   = (ptr_reg != at_f);
    assign srch_issue = (ptr_reg != '0);

    always_comb
    begin
        st.func      = func_reg;
        st.full      = (fill_reg == swrdi_pkg::FW'(swrdi_pkg::DEPTH));
        st.empty     = (fill_reg == '0);
        st.del_ok    = (pos_c != '0) && (del_end <= fill_c + 1'b1);
        st.cnt_zero  = (cnt_reg == '0);
        st.rd_ok     = (pos_c != '0) && (pos_c <= fill_c);
        st.match     = pend_reg && (ram_rdata == key_reg);
        st.srch_done = (ptr_reg == '0) && !pend_reg;
        st.dn_done   = !del_issue && !pend_reg;
        st.up_done   = !up_issue && !pend_reg;
    end

    always_comb
    begin
        ram_raddr = fill_m1[swrdi_pkg::AW-1:0];
        if (cmd.pos_rd)
        begin
            ram_raddr = pos_addr;
        end
        else if (cmd.del_step)
        begin
            ram_raddr = ptr_reg[swrdi_pkg::AW-1:0];
        end
        else if (cmd.srch_step || cmd.ins_step)
        begin
            ram_raddr = ptr_m1[swrdi_pkg::AW-1:0];
        end

        ram_we    = 1'b0;
        ram_waddr = fill_reg[swrdi_pkg::AW-1:0];
        ram_wdata = value_reg;
        if (cmd.push)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.del_step && pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = dst_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.ins_step && pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = a_p1;
            ram_wdata = ram_rdata;
        end
        else if (cmd.ins_fin)
        begin
            ram_we    = 1'b1;
            ram_waddr = at_reg;
        end
    end

    always_comb
    begin
        fill_next   = fill_reg;
        ptr_next    = ptr_reg;
        a_next      = a_reg;
        at_next     = at_reg;
        dst_next    = dst_reg;
        pend_next   = pend_reg;
        data_next   = data_reg;
        status_next = status_reg;

        if (cmd.load)
        begin
            data_next   = '0;
            status_next = swrdi_pkg::ST_OK;
        end
        if (cmd.set_st)
        begin
            status_next = cmd.st_code;
        end
        if (cmd.push || cmd.ins_fin)
        begin
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.pop_rd)
        begin
            fill_next = fill_m1;
        end
        if (cmd.cap_data)
        begin
            data_next = swrdi_pkg::from_word(ram_rdata);
        end
        if (cmd.del_init)
        begin
            ptr_next  = swrdi_pkg::FW'(src_init);
            dst_next  = pos_addr;
            pend_next = 1'b0;
        end
        if (cmd.del_step)
        begin
            pend_next = del_issue;
            if (del_issue)
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            if (pend_reg)
            begin
                dst_next = dst_reg + 1'b1;
            end
        end
        if (cmd.del_fin)
        begin
            fill_next = fill_reg - swrdi_pkg::FW'(cnt_reg);
        end
        if (cmd.srch_init)
        begin
            ptr_next  = fill_reg;
            pend_next = 1'b0;
        end
        if (cmd.srch_step)
        begin
            pend_next = srch_issue;
            if (srch_issue)
            begin
                ptr_next = ptr_m1;
                a_next   = ptr_m1[swrdi_pkg::AW-1:0];
            end
        end
        if (cmd.ins_init)
        begin
            at_next   = a_reg;
            ptr_next  = fill_reg;
            pend_next = 1'b0;
        end
        if (cmd.ins_step)
        begin
            pend_next = up_issue;
            if (up_issue)
            begin
                ptr_next = ptr_m1;
                a_next   = ptr_m1[swrdi_pkg::AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            value_reg <= swrdi_pkg::to_word(value);
            key_reg   <= swrdi_pkg::to_word(key);
            pos_reg   <= position;
            cnt_reg   <= count;
        end
        ptr_reg    <= ptr_next;
        a_reg      <= a_next;
        at_reg     <= at_next;
        dst_reg    <= dst_next;
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    assign data   = data_reg;
    assign status = status_reg;
    assign fill   = swrdi_pkg::FILL_W'(fill_reg);

endmodule
`default_nettype wire

// ----- design/stack_with_range_delete_insert_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stack_with_range_delete_insert_unit: LIFO stack with range delete and
// keyed insert
// Push, pop, positional read, delete of a run of entries and insert below
// the topmost entry equal to a key. One result per operation.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its result shows
// on data, status and fill for exactly one cycle with done high, and must be
// captured then. busy stays high from the accepting edge through the done
// cycle, so a new operation can start in the cycle after done. The entries
// sit in a RAM with one read and one write port, so shifting moves one entry
// per cycle: a delete shifts down the entries above the deleted run, and an
// insert makes a search pass from the top down to the matching key, then a
// shift pass that moves the entries from the top down to the key up by one.
// Failed operations leave the stack untouched.
// ----------------------------------------------------------------------------
module stack_with_range_delete_insert_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [swrdi_pkg::FUNC_W-1:0]   func,
    input  wire logic [swrdi_pkg::DATA_W-1:0]   value,
    input  wire logic [swrdi_pkg::POS_W-1:0]    position,
    input  wire logic [swrdi_pkg::POS_W-1:0]    count,
    input  wire logic [swrdi_pkg::DATA_W-1:0]   key,
    output logic                                busy,
    output logic                                done,
    output logic      [swrdi_pkg::DATA_W-1:0]   data,
    output logic      [swrdi_pkg::STAT_W-1:0]   status,
    output logic      [swrdi_pkg::FILL_W-1:0]   fill
);

    swrdi_pkg::dp_cmd_t  cmd;
    swrdi_pkg::dp_stat_t st;

    swrdi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    swrdi_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .func     (func),
        .value    (value),
        .position (position),
        .count    (count),
        .key      (key),
        .st       (st),
        .data     (data),
        .status   (status),
        .fill     (fill)
    );

endmodule
`default_nettype wire

// ----- design/swrdi_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrdi_chk: port-level checks for the stack unit
// Handshake sequencing, fill bound and error result contents.
// ----------------------------------------------------------------------------
module swrdi_chk (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           done,
    input wire logic [swrdi_pkg::DATA_W-1:0]   data,
    input wire logic [swrdi_pkg::STAT_W-1:0]   status,
    input wire logic [swrdi_pkg::FILL_W-1:0]   fill
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer accepted but busy not raised");

    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside an operation");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("unit not free after result transfer");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill) <= swrdi_pkg::DEPTH)
        else $error("fill above depth");

    a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != swrdi_pkg::ST_OK) |-> (data == '0))
        else $error("error result with nonzero data");

endmodule

bind stack_with_range_delete_insert_unit swrdi_chk u_swrdi_chk (.*);
`default_nettype wire
